FILE: sv/cmia_pkg.sv
package cmia_pkg;

    // Reflected CRC-32C polynomial and seed
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Number of check bytes appended after the last payload byte
    localparam int unsigned CHECK_BYTES = 4;
    localparam int unsigned CNT_W       = $clog2(CHECK_BYTES + 1);

    // Register map, index = paddr / 4
    localparam logic REG_MIC_ENABLE = 1'b0;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] crc_t;
    typedef logic [CNT_W-1:0] tail_cnt_t;

    // One byte through the reflected CRC, LSB first, eight bit steps
    function automatic crc_t crc_byte(input crc_t crc_in, input byte_t data);
        crc_t c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: sv/crc32c_message_integrity_append_core.sv
// Channel   Dir  tdata          tuser          tlast
// s_axis    in   payload_byte   -              payload_last
// m_axis    out  out_byte       is_check_byte  message_end
// apb       in   mic_enable at 0x0
//
// One payload byte is taken per cycle unless the output stalls or check bytes are
// pending; the CRC update is one unrolled byte step. A last byte with checking
// enabled yields five output bytes, so the input is held off until the four
// check bytes are in the output register. Input and output are parted by one
// output register; a stalled output blocks the input only when it cannot be refilled.
// rst_n clears the output valid flag and the tail count, sets the CRC to all ones
// and mic_enable to 1.
module crc32c_message_integrity_append_core
(
    input  logic        clk,
    input  logic        rst_n,
    // payload_byte [7:0]
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // out_byte [7:0]
    output logic [7:0]  m_axis_tdata,
    // is_check_byte [0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                  mic_enable_reg;
    cmia_pkg::crc_t        crc_reg;
    cmia_pkg::crc_t        crc_next;
    cmia_pkg::crc_t        crc_upd;
    cmia_pkg::crc_t        tail_reg;
    cmia_pkg::crc_t        tail_next;
    cmia_pkg::tail_cnt_t   tail_cnt_reg;
    cmia_pkg::tail_cnt_t   tail_cnt_next;
    cmia_pkg::byte_t       out_byte_reg;
    cmia_pkg::byte_t       out_byte_next;
    logic                  out_chk_reg;
    logic                  out_chk_next;
    logic                  out_end_reg;
    logic                  out_end_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  s_fire;
    logic                  load_en;
    logic                  tail_busy;
    logic                  cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mic_enable_reg <= 1'b1;
        else if (cfg_wr && paddr[2] == cmia_pkg::REG_MIC_ENABLE)
            mic_enable_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = 32'h0;
        if (paddr[2] == cmia_pkg::REG_MIC_ENABLE)
            prdata = {31'h0, mic_enable_reg};
    end

    // Handshakes
    assign tail_busy     = (tail_cnt_reg != '0);
    assign load_en       = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = load_en & ~tail_busy;
    assign s_fire        = s_axis_tvalid & s_axis_tready;

    // CRC accumulator
    assign crc_upd = cmia_pkg::crc_byte(crc_reg, s_axis_tdata);

    always_comb
    begin
        crc_next = crc_reg;
        if (s_fire)
        begin
            if (s_axis_tlast)
                crc_next = cmia_pkg::CRC_INIT;
            else if (mic_enable_reg)
                crc_next = crc_upd;
        end
    end

    // Output register and check byte tail
    always_comb
    begin
        out_byte_next  = out_byte_reg;
        out_chk_next   = out_chk_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg;
        tail_next      = tail_reg;
        tail_cnt_next  = tail_cnt_reg;
        if (load_en)
        begin
            if (tail_busy)
            begin
                out_byte_next  = tail_reg[7:0];
                out_chk_next   = 1'b1;
                out_end_next   = (tail_cnt_reg == cmia_pkg::tail_cnt_t'(1));
                out_valid_next = 1'b1;
                tail_next      = tail_reg >> 8;
                tail_cnt_next  = tail_cnt_reg - cmia_pkg::tail_cnt_t'(1);
            end
            else if (s_fire)
            begin
                out_byte_next  = s_axis_tdata;
                out_chk_next   = 1'b0;
                out_end_next   = s_axis_tlast & ~mic_enable_reg;
                out_valid_next = 1'b1;
                if (s_axis_tlast && mic_enable_reg)
                begin
                    tail_next     = ~crc_upd;
                    tail_cnt_next = cmia_pkg::tail_cnt_t'(cmia_pkg::CHECK_BYTES);
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= cmia_pkg::CRC_INIT;
            tail_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            tail_cnt_reg  <= tail_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        tail_reg     <= tail_next;
        out_byte_reg <= out_byte_next;
        out_chk_reg  <= out_chk_next;
        out_end_reg  <= out_end_next;
    end

    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_chk_reg;
    assign m_axis_tlast  = out_end_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule

FILE: sv/cmia_checker.sv
module cmia_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // Stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

    // No input while check bytes are still queued
    a_tail_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken during check byte tail");

    // An accepted input always shows up on the next cycle
    a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted input lost");

    // Check bytes run back to back until the final one
    a_tail_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser))
        else $error("check byte sequence broken");

endmodule

bind crc32c_message_integrity_append_core cmia_checker u_cmia_checker (.*);
